### rtl/core/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
package fpba_pkg;

   localparam int AMOUNT_W = 16;
   localparam int INDEX_W  = 4;
   localparam int PID_W    = 16;
   localparam int POLICY_W = 2;

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   // The unused fourth policy code behaves as first fit.
   localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

   typedef enum logic [1:0] {
      STAT_ALLOCATED = 2'd0,
      STAT_NO_FIT    = 2'd1,
      STAT_ADDED     = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                clear;
      logic                cmp_en;
      logic [POLICY_W-1:0] policy;
   } sel_ctl_type;

endpackage

### rtl/core/fpba_if.sv
// Request and response channel interfaces for the fit-policy block allocator.
interface fpba_req_if;
   import fpba_pkg::*;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [AMOUNT_W-1:0] amount;
   logic                usable;
   modport source (output valid, req_type, amount, usable, input ready);
   modport sink   (input valid, req_type, amount, usable, output ready);
endinterface

interface fpba_rsp_if;
   import fpba_pkg::*;
   logic                valid;
   logic                ready;
   status_type          status;
   logic [INDEX_W-1:0]  block_index;
   logic [PID_W-1:0]    process_id;
   logic [AMOUNT_W-1:0] free_left;
   modport source (output valid, status, block_index, process_id, free_left, input ready);
   modport sink   (input valid, status, block_index, process_id, free_left, output ready);
endinterface

### rtl/core/fit_policy_block_allocator.sv
// Top level of the fit-policy block allocator: sequencer, registers and channels.
//
//   Port      Dir  Role
//   req_if    in   add a block or allocate a request (valid/ready)
//   rsp_if    out  one response per request (valid/ready)
//   csr_*     in   fit policy register write
//
// An allocate reads the table one block per cycle through its single read port, and each
// entry passes the shared compare unit; an allocate with an empty table reads no block.
// Reset is synchronous; it empties the table, sets the id counter to one and the policy
// to first fit. A held response stalls the sequencer in its final state; one new request
// may be accepted while the previous response still waits.
module fit_policy_block_allocator #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   fpba_req_if.sink                  req_if,
   fpba_rsp_if.source                rsp_if,
   input  logic                      csr_wr_en,
   input  logic [fpba_pkg::POLICY_W-1:0] csr_wr_data
);
   import fpba_pkg::*;

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   state_type             state_ff, state_in;
   logic [POLICY_W-1:0]   policy_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PID_W-1:0]      next_id_ff, next_id_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  data_vld_ff;
   logic [IDX_W-1:0]      data_idx_ff;
   logic [SIZE_WIDTH-1:0] amt_ff;
   logic                  usable_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [PID_W-1:0]      rsp_pid_ff, rsp_pid_in;
   logic [AMOUNT_W-1:0]   rsp_left_ff, rsp_left_in;
   logic                  rsp_load;

   logic                  accept, out_free, table_full, scan_last;
   logic [CNT_W-1:0]      scan_next_cnt;
   logic [SIZE_WIDTH+AMOUNT_W-1:0] amt_wide;
   logic [IDX_W+INDEX_W-1:0]       add_idx_wide, pick_idx_wide;
   logic [SIZE_WIDTH+AMOUNT_W-1:0] add_left_wide, pick_left_wide;

   logic                  mem_we, mem_wuse, mem_re;
   logic [IDX_W-1:0]      mem_waddr;
   logic [SIZE_WIDTH-1:0] mem_wfs, rd_fs;
   logic                  rd_use;

   sel_ctl_type           sel_ctl;
   logic                  sel_found;
   logic [IDX_W-1:0]      sel_idx;
   logic [SIZE_WIDTH-1:0] sel_left;

   fpba_table #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_WIDTH (SIZE_WIDTH),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_fs   (mem_wfs),
      .wr_use  (mem_wuse),
      .rd_en   (mem_re),
      .rd_addr (scan_idx_ff),
      .rd_fs   (rd_fs),
      .rd_use  (rd_use)
   );

   fpba_select #(
      .SIZE_WIDTH (SIZE_WIDTH),
      .IDX_W      (IDX_W)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sel_ctl),
      .rd_fs     (rd_fs),
      .rd_use    (rd_use),
      .rd_idx    (data_idx_ff),
      .amt       (amt_ff),
      .found     (sel_found),
      .pick_idx  (sel_idx),
      .pick_left (sel_left)
   );

   assign accept        = req_if.valid && req_if.ready;
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign table_full    = (count_ff == CNT_W'(NUM_BLOCKS));
   assign scan_next_cnt = CNT_W'(scan_idx_ff) + CNT_W'(1);
   assign scan_last     = (scan_next_cnt == count_ff);

   // The amount is taken modulo the storage width.
   assign amt_wide       = {{SIZE_WIDTH{1'b0}}, req_if.amount};
   assign add_idx_wide   = {{INDEX_W{1'b0}}, count_ff[IDX_W-1:0]};
   assign pick_idx_wide  = {{INDEX_W{1'b0}}, sel_idx};
   assign add_left_wide  = {{AMOUNT_W{1'b0}}, amt_ff};
   assign pick_left_wide = {{AMOUNT_W{1'b0}}, sel_left};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_if.req_type == REQ_ADD) begin
                  state_in = S_ADD;
               end else if (count_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_ADD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_if.ready   = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = count_ff[IDX_W-1:0];
      mem_wfs        = amt_ff;
      mem_wuse       = usable_ff;
      mem_re         = 1'b0;
      sel_ctl.clear  = 1'b0;
      sel_ctl.cmp_en = data_vld_ff;
      sel_ctl.policy = policy_ff;
      count_in       = count_ff;
      next_id_in     = next_id_ff;
      scan_idx_in    = scan_idx_ff;
      rsp_load       = 1'b0;
      rsp_status_in  = STAT_NO_FIT;
      rsp_index_in   = '0;
      rsp_pid_in     = '0;
      rsp_left_in    = '0;
      case (state_ff)
         S_IDLE: begin
            req_if.ready  = 1'b1;
            sel_ctl.clear = accept;
            scan_idx_in   = '0;
         end
         S_ADD: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (table_full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  mem_we        = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  rsp_status_in = STAT_ADDED;
                  rsp_index_in  = add_idx_wide[INDEX_W-1:0];
                  rsp_left_in   = add_left_wide[AMOUNT_W-1:0];
               end
            end
         end
         S_SCAN: begin
            mem_re      = 1'b1;
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
         S_DRAIN: begin
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (sel_found) begin
                  // A chosen block is usable by definition.
                  mem_we        = 1'b1;
                  mem_waddr     = sel_idx;
                  mem_wfs       = sel_left;
                  mem_wuse      = 1'b1;
                  next_id_in    = next_id_ff + PID_W'(1);
                  rsp_status_in = STAT_ALLOCATED;
                  rsp_index_in  = pick_idx_wide[INDEX_W-1:0];
                  rsp_pid_in    = next_id_ff;
                  rsp_left_in   = pick_left_wide[AMOUNT_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= POL_FIRST;
         count_ff     <= '0;
         next_id_ff   <= PID_W'(1);
         scan_idx_ff  <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         scan_idx_ff  <= scan_idx_in;
         data_vld_ff  <= mem_re;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_idx_ff <= scan_idx_ff;
      if (accept) begin
         amt_ff    <= amt_wide[SIZE_WIDTH-1:0];
         usable_ff <= req_if.usable;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_pid_ff    <= rsp_pid_in;
         rsp_left_ff   <= rsp_left_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.block_index = rsp_index_ff;
   assign rsp_if.process_id  = rsp_pid_ff;
   assign rsp_if.free_left   = rsp_left_ff;

endmodule

### rtl/core/fpba_table.sv
// Block table memory: free space and usable flag per block, registered read.
module fpba_table #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16,
   parameter int IDX_W      = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic [SIZE_WIDTH-1:0] wr_fs,
   input  logic                  wr_use,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output logic [SIZE_WIDTH-1:0] rd_fs,
   output logic                  rd_use
);
   logic [SIZE_WIDTH:0] mem [NUM_BLOCKS];
   logic [SIZE_WIDTH:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_use, wr_fs};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_fs  = rd_data_ff[SIZE_WIDTH-1:0];
   assign rd_use = rd_data_ff[SIZE_WIDTH];

endmodule

### rtl/core/fpba_select.sv
// Shared compare unit: tracks the block chosen by the fit policy during a scan.
module fpba_select #(
   parameter int SIZE_WIDTH = 16,
   parameter int IDX_W      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fpba_pkg::sel_ctl_type ctl,
   input  logic [SIZE_WIDTH-1:0] rd_fs,
   input  logic                  rd_use,
   input  logic [IDX_W-1:0]      rd_idx,
   input  logic [SIZE_WIDTH-1:0] amt,
   output logic                  found,
   output logic [IDX_W-1:0]      pick_idx,
   output logic [SIZE_WIDTH-1:0] pick_left
);
   import fpba_pkg::*;

   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_idx_ff;
   logic [SIZE_WIDTH-1:0] pick_fs_ff;
   logic                  fits, better, take;

   always_comb begin
      fits   = rd_use && (rd_fs >= amt);
      // Strict compares keep the lowest index on ties.
      better = !found_ff
               || ((ctl.policy == POL_BEST) && (rd_fs < pick_fs_ff))
               || ((ctl.policy == POL_WORST) && (rd_fs > pick_fs_ff));
      take   = ctl.cmp_en && fits && better;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else begin
         found_in = found_ff | take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pick_idx_ff <= rd_idx;
         pick_fs_ff  <= rd_fs;
      end
   end

   assign found     = found_ff;
   assign pick_idx  = pick_idx_ff;
   assign pick_left = pick_fs_ff - amt;

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fit-policy block allocator.
module tb;
   import fpba_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int PHASE_ITEMS = 100;
   localparam int DRAIN_WAIT  = 24;
   localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

   typedef struct packed {
      status_type          status;
      logic [INDEX_W-1:0]  block_index;
      logic [PID_W-1:0]    process_id;
      logic [AMOUNT_W-1:0] free_left;
   } placement_type;

   typedef enum logic [1:0] {
      ROW_REQ,
      ROW_POLICY
   } row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic                req_type;
      logic [AMOUNT_W-1:0] amount;
      logic                usable;
      logic [POLICY_W-1:0] policy;
      logic                typed;
      placement_type       want;
   } stim_row_type;

   localparam placement_type NO_FIT_RSP = '{STAT_NO_FIT, 4'd0, 16'd0, 16'd0};
   localparam placement_type FULL_RSP   = '{STAT_FULL, 4'd0, 16'd0, 16'd0};
   localparam placement_type UNTYPED    = '{STAT_ALLOCATED, 4'd0, 16'd0, 16'd0};

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [POLICY_W-1:0] csr_wr_data;

   fpba_req_if req_if();
   fpba_rsp_if rsp_if();

   fit_policy_block_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the block table, id counter and policy.
   logic [AMOUNT_W-1:0] blk_free [TABLE_DEPTH];
   logic                blk_usable [TABLE_DEPTH];
   int                  blk_count;
   logic [PID_W-1:0]    id_next;
   logic [POLICY_W-1:0] active_policy;

   placement_type placements_due[$];
   stim_row_type  script [32];

   int            errors;
   int            n_granted;
   int            n_missed;
   int            n_added;
   int            n_full;
   bit            steady;
   int            stall_left;
   bit            row_typed;
   placement_type row_want;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one request to the shadow table and returns the placement it produces.
   function automatic placement_type place_request(input logic kind,
                                                   input logic [AMOUNT_W-1:0] amt,
                                                   input logic use_ok);
      placement_type p;
      bit            found;
      int            pick;
      int            i;
      p = NO_FIT_RSP;
      found = 1'b0;
      pick = 0;
      if (kind == REQ_ADD) begin
         if (blk_count >= TABLE_DEPTH) begin
            p = FULL_RSP;
         end else begin
            blk_free[blk_count] = amt;
            blk_usable[blk_count] = use_ok;
            p.status = STAT_ADDED;
            p.block_index = blk_count[INDEX_W-1:0];
            p.free_left = amt;
            blk_count++;
         end
      end else begin
         // First fit keeps the first candidate; only best and worst fit replace it,
         // and only on a strict improvement so that ties stay at the lowest index.
         for (i = 0; i < blk_count; i++) begin
            if (blk_usable[i] && blk_free[i] >= amt) begin
               if (!found) begin
                  found = 1'b1;
                  pick = i;
               end else if (active_policy == POL_BEST && blk_free[i] < blk_free[pick]) begin
                  pick = i;
               end else if (active_policy == POL_WORST && blk_free[i] > blk_free[pick]) begin
                  pick = i;
               end
            end
         end
         if (found) begin
            blk_free[pick] = blk_free[pick] - amt;
            p.status = STAT_ALLOCATED;
            p.block_index = pick[INDEX_W-1:0];
            p.process_id = id_next;
            p.free_left = blk_free[pick];
            id_next = id_next + 1'b1;
         end
      end
      return p;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [AMOUNT_W-1:0] pick_request_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 55) return AMOUNT_W'($urandom_range(1, 255));
      if (r < 92) return AMOUNT_W'($urandom_range(256, 2047));
      if (r < 97) return AMOUNT_W'($urandom_range(0, 65535));
      return '1;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input logic kind, input logic [AMOUNT_W-1:0] amt,
                               input logic use_ok, input bit typed,
                               input placement_type want);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= kind;
      req_if.amount <= amt;
      req_if.usable <= use_ok;
      row_typed = typed;
      row_want = want;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // The policy register is only written once every placement has come back.
   task automatic write_policy(input logic [POLICY_W-1:0] pol);
      req_if.valid <= 1'b0;
      while (placements_due.size() != 0) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= pol;
      active_policy = pol;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : monitor
      placement_type want;
      placement_type fresh;
      if (!reset) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (placements_due.size() == 0) begin
               errors++;
               $display("%0t: response with no request outstanding", $time);
            end else begin
               want = placements_due.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_if.status));
               check_field("block_index", 32'(want.block_index), 32'(rsp_if.block_index));
               check_field("process_id", 32'(want.process_id), 32'(rsp_if.process_id));
               check_field("free_left", 32'(want.free_left), 32'(rsp_if.free_left));
            end
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            fresh = place_request(req_if.req_type, req_if.amount, req_if.usable);
            if (row_typed) fresh = row_want;
            case (fresh.status)
               STAT_ALLOCATED: n_granted++;
               STAT_NO_FIT:    n_missed++;
               STAT_ADDED:     n_added++;
               default:        n_full++;
            endcase
            placements_due = {placements_due, fresh};
         end
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!steady && $urandom_range(0, 2) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      #100_000_000;
      $display("[fit_policy_block_allocator] ERROR");
      $finish;
   end

   initial begin
      logic [POLICY_W-1:0] phase_pol [4];
      logic                kind;
      int                  k;
      int                  n;
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = POL_FIRST;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_ADD;
      req_if.amount = '0;
      req_if.usable = 1'b0;
      steady = 1'b0;
      row_typed = 1'b0;
      row_want = UNTYPED;
      errors = 0;
      n_granted = 0;
      n_missed = 0;
      n_added = 0;
      n_full = 0;
      blk_count = 0;
      id_next = PID_W'(1);
      active_policy = POL_FIRST;
      phase_pol = '{POL_BEST, POL_WORST, POL_FIRST, POL_SPARE};

      script = '{
         '{ROW_POLICY, REQ_ADD, 16'd0, 1'b0, POL_FIRST, 1'b0, UNTYPED},
         '{ROW_REQ, REQ_ALLOC, 16'd5, 1'b0, POL_FIRST, 1'b1, NO_FIT_RSP},
         '{ROW_REQ, REQ_ADD, 16'd100, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd0, 16'd0, 16'd100}},
         '{ROW_REQ, REQ_ALLOC, 16'd0, 1'b0, POL_FIRST, 1'b1,
           '{STAT_ALLOCATED, 4'd0, 16'd1, 16'd100}},
         '{ROW_REQ, REQ_ADD, 16'd65535, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd1, 16'd0, 16'd65535}},
         '{ROW_REQ, REQ_ADD, 16'd50, 1'b0, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd2, 16'd0, 16'd50}},
         '{ROW_REQ, REQ_ADD, 16'd30, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd3, 16'd0, 16'd30}},
         '{ROW_REQ, REQ_ADD, 16'd200, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd4, 16'd0, 16'd200}},
         '{ROW_REQ, REQ_ALLOC, 16'd40, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ALLOCATED, 4'd0, 16'd2, 16'd60}},
         '{ROW_REQ, REQ_ALLOC, 16'd65535, 1'b0, POL_FIRST, 1'b1,
           '{STAT_ALLOCATED, 4'd1, 16'd3, 16'd0}},
         '{ROW_REQ, REQ_ALLOC, 16'd70, 1'b1, POL_FIRST, 1'b0, UNTYPED},
         '{ROW_POLICY, REQ_ADD, 16'd0, 1'b0, POL_BEST, 1'b0, UNTYPED},
         '{ROW_REQ, REQ_ALLOC, 16'd30, 1'b0, POL_FIRST, 1'b0, UNTYPED},
         '{ROW_REQ, REQ_ALLOC, 16'd60, 1'b1, POL_FIRST, 1'b0, UNTYPED},
         '{ROW_POLICY, REQ_ADD, 16'd0, 1'b0, POL_WORST, 1'b0, UNTYPED},
         '{ROW_REQ, REQ_ALLOC, 16'd10, 1'b0, POL_FIRST, 1'b0, UNTYPED},
         '{ROW_REQ, REQ_ADD, 16'd120, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd5, 16'd0, 16'd120}},
         '{ROW_REQ, REQ_ALLOC, 16'd5, 1'b1, POL_FIRST, 1'b0, UNTYPED},
         '{ROW_POLICY, REQ_ADD, 16'd0, 1'b0, POL_SPARE, 1'b0, UNTYPED},
         '{ROW_REQ, REQ_ALLOC, 16'd1, 1'b0, POL_FIRST, 1'b0, UNTYPED},
         '{ROW_REQ, REQ_ALLOC, 16'd40000, 1'b1, POL_FIRST, 1'b1, NO_FIT_RSP},
         '{ROW_REQ, REQ_ADD, 16'd65535, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd6, 16'd0, 16'd65535}},
         '{ROW_REQ, REQ_ADD, 16'd0, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd7, 16'd0, 16'd0}},
         '{ROW_REQ, REQ_ADD, 16'd65535, 1'b0, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd8, 16'd0, 16'd65535}},
         '{ROW_REQ, REQ_ADD, 16'd65535, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd9, 16'd0, 16'd65535}},
         '{ROW_REQ, REQ_ADD, 16'd32768, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd10, 16'd0, 16'd32768}},
         '{ROW_REQ, REQ_ADD, 16'd65535, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd11, 16'd0, 16'd65535}},
         '{ROW_REQ, REQ_ADD, 16'd32767, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd12, 16'd0, 16'd32767}},
         '{ROW_REQ, REQ_ADD, 16'd65535, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd13, 16'd0, 16'd65535}},
         '{ROW_REQ, REQ_ADD, 16'd21845, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd14, 16'd0, 16'd21845}},
         '{ROW_REQ, REQ_ADD, 16'd65535, 1'b1, POL_FIRST, 1'b1,
           '{STAT_ADDED, 4'd15, 16'd0, 16'd65535}},
         '{ROW_REQ, REQ_ADD, 16'd65535, 1'b1, POL_FIRST, 1'b1, FULL_RSP}
      };

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         case (script[k].kind)
            ROW_REQ: send_request(script[k].req_type, script[k].amount, script[k].usable,
                                  script[k].typed, script[k].want);
            ROW_POLICY: write_policy(script[k].policy);
            default: begin
            end
         endcase
      end

      for (k = 0; k < 4; k++) begin
         write_policy(phase_pol[k]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 25 == 0) steady = ($urandom_range(0, 3) == 0);
            kind = ($urandom_range(0, 99) < 12) ? REQ_ADD : REQ_ALLOC;
            if (kind == REQ_ADD) begin
               send_request(kind, AMOUNT_W'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)), 1'b0, UNTYPED);
            end else begin
               send_request(kind, pick_request_size(), 1'($urandom_range(0, 1)),
                            1'b0, UNTYPED);
            end
         end
      end
      steady = 1'b0;

      req_if.valid <= 1'b0;
      while (placements_due.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("Checked %0d requests: %0d allocations, %0d misses, %0d adds, %0d full adds.",
               n_granted + n_missed + n_added + n_full, n_granted, n_missed, n_added,
               n_full);
      $display("All four policy codes were used, and the table was filled past its end.");
      if (errors == 0) begin
         $display("[fit_policy_block_allocator] OK");
      end else begin
         $display("[fit_policy_block_allocator] ERROR");
      end
      $finish;
   end

endmodule
